[hdl/mcbp_pkg.sv]
package mcbp_pkg;

    // Parse phases
    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_VCOUNT = 4'd1;
    localparam logic [3:0] PH_FCOUNT = 4'd2;
    localparam logic [3:0] PH_VERTS  = 4'd3;
    localparam logic [3:0] PH_FACES  = 4'd4;
    localparam logic [3:0] PH_PAD_N  = 4'd5;
    localparam logic [3:0] PH_SKIP_N = 4'd6;
    localparam logic [3:0] PH_PAD_U  = 4'd7;
    localparam logic [3:0] PH_SKIP_U = 4'd8;
    localparam logic [3:0] PH_DONE   = 4'd9;
    localparam logic [3:0] PH_IDLE   = 4'd10;

    // Result kinds
    localparam logic [1:0] KIND_COORD  = 2'd0;
    localparam logic [1:0] KIND_FACE   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_PLAIN = 3'd1;
    localparam logic [2:0] ST_TOO_SMALL = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
    localparam logic [2:0] ST_BAD_VER   = 3'd4;
    localparam logic [2:0] ST_CRC       = 3'd5;
    localparam logic [2:0] ST_TRUNC     = 3'd6;

    // Header error codes
    localparam logic [1:0] HERR_NONE  = 2'd0;
    localparam logic [1:0] HERR_MAGIC = 2'd1;
    localparam logic [1:0] HERR_VER   = 2'd2;

    // Header byte offsets
    localparam logic [3:0] HDR_VERSION = 4'd4;
    localparam logic [3:0] HDR_PRIM    = 4'd5;
    localparam logic [3:0] HDR_FLAGS0  = 4'd6;
    localparam logic [3:0] HDR_FLAGS1  = 4'd7;
    localparam logic [3:0] HDR_UNITS0  = 4'd8;
    localparam logic [3:0] HDR_UNITS1  = 4'd9;
    localparam logic [3:0] HDR_CRC0    = 4'd12;
    localparam logic [3:0] HDR_LAST    = 4'd15;

    localparam logic [7:0]  VERSION_ONE = 8'd1;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    // Flag bits
    localparam int FLAG_NOT_PLAIN = 0;
    localparam int FLAG_NORMALS   = 4;
    localparam int FLAG_UVS       = 5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] coord_bits;
        logic [31:0] face_index;
        logic [2:0]  status;
        logic [3:0]  units;
        logic        final_res;
    } result_t;

    // Up to two results produced by one input byte
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0: m = 8'h53;
            2'd1: m = 8'h47;
            2'd2: m = 8'h45;
            2'd3: m = 8'h4F;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

[hdl/mesh_container_byte_parser_core.sv]
// Mesh container byte parser. Takes one container byte per transfer on the s_axis side
// (s_axis_tlast marks the final byte of a buffer) and checks the 16-byte header (magic,
// version, primitive kind, flags, units, expected CRC-32), runs a CRC-32 over every body
// byte, and emits each 64-bit vertex coordinate word (m_axis_tuser = 0) and each signed
// 32-bit face index (m_axis_tuser = 1) as soon as its last byte arrives. Normals and UVs,
// when flagged, are skipped after 8-byte alignment; colours and trailing bytes are ignored.
// The final byte of a buffer yields a status transfer (m_axis_tuser = 2, m_axis_tlast = 1)
// carrying the status and mapped units code; coordinate and face transfers go out before
// that verdict, so drop them when the status is nonzero. After the final byte the parser
// returns to its reset state for the next buffer. Throughput is one byte per clock: the
// byte-wide CRC and field assembly finish in the cycle the byte is taken, and a four-entry
// result queue absorbs the second transfer of a byte that both completes a word and ends
// the buffer. s_axis_tready drops only while that queue holds more than two results, i.e.
// when the m_axis side stalls.
module mesh_container_byte_parser_core
    import mcbp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] byte_in
    input  logic         s_axis_tlast,   // end_of_buffer

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] coord_bits, [95:64] face_index, [98:96] status, [102:99] units, [103] zero
    output logic [103:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast    // final_res
);

    logic    in_acc;
    push_t   push;
    result_t out_res;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    mcbp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_acc  (in_acc),
        .in_byte (s_axis_tdata),
        .in_eob  (s_axis_tlast),
        .push    (push)
    );

    mcbp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.units, out_res.status,
                           out_res.face_index, out_res.coord_bits};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.final_res;

endmodule

[hdl/mcbp_parser.sv]
module mcbp_parser
    import mcbp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_acc,
    input  logic [7:0] in_byte,
    input  logic       in_eob,
    output push_t      push
);

    logic [3:0]  pos_reg, pos_next;
    logic [3:0]  phase_reg, phase_next;
    logic [63:0] asm_reg, asm_next;
    logic [15:0] flags_reg, flags_next;
    logic [7:0]  prim_reg, prim_next;
    logic [15:0] units_reg, units_next;
    logic [31:0] exp_crc_reg, exp_crc_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] vcount_reg, vcount_next;
    logic [31:0] fcount_reg, fcount_next;
    logic [39:0] left_reg, left_next;
    logic [1:0]  herr_reg, herr_next;

    logic [1:0]  s4;
    logic [2:0]  s8;
    logic        aligned;
    logic        not_plain;
    logic        data_vld;
    result_t     data_res;
    result_t     fin_res;

    assign s4 = pos_reg[1:0];
    assign s8 = pos_reg[2:0];

    always_comb begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        asm_next     = asm_reg;
        flags_next   = flags_reg;
        prim_next    = prim_reg;
        units_next   = units_reg;
        exp_crc_next = exp_crc_reg;
        crc_next     = crc_reg;
        vcount_next  = vcount_reg;
        fcount_next  = fcount_reg;
        left_next    = left_reg;
        herr_next    = herr_reg;
        data_vld     = 1'b0;
        data_res     = '0;
        fin_res      = '0;
        aligned      = 1'b0;
        not_plain    = 1'b0;

        if (in_acc) begin
            if (phase_reg == PH_HEADER) begin
                if (pos_reg < HDR_VERSION) begin
                    if (in_byte != magic_byte(pos_reg[1:0]) && herr_reg == HERR_NONE) begin
                        herr_next = HERR_MAGIC;
                    end
                end else if (pos_reg == HDR_VERSION) begin
                    if (in_byte != VERSION_ONE && herr_reg == HERR_NONE) begin
                        herr_next = HERR_VER;
                    end
                end else if (pos_reg == HDR_PRIM) begin
                    prim_next = in_byte;
                end else if (pos_reg == HDR_FLAGS0) begin
                    flags_next[7:0] = flags_reg[7:0] | in_byte;
                end else if (pos_reg == HDR_FLAGS1) begin
                    flags_next[15:8] = flags_reg[15:8] | in_byte;
                end else if (pos_reg == HDR_UNITS0) begin
                    units_next[7:0] = units_reg[7:0] | in_byte;
                end else if (pos_reg == HDR_UNITS1) begin
                    units_next[15:8] = units_reg[15:8] | in_byte;
                end else if (pos_reg >= HDR_CRC0) begin
                    exp_crc_next = exp_crc_reg | (32'(in_byte) << {s4, 3'b000});
                end
                if (pos_reg == HDR_LAST) begin
                    if (herr_next != HERR_NONE || prim_next != 8'd0
                        || flags_next[FLAG_NOT_PLAIN]) begin
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_VCOUNT;
                    end
                end
            end else begin
                crc_next = crc_byte(crc_reg, in_byte);
                unique case (phase_reg)
                    PH_VCOUNT: begin
                        vcount_next = vcount_reg | (32'(in_byte) << {s4, 3'b000});
                        if (s4 == 2'd3) phase_next = PH_FCOUNT;
                    end
                    PH_FCOUNT: begin
                        fcount_next = fcount_reg | (32'(in_byte) << {s4, 3'b000});
                        if (s4 == 2'd3) begin
                            phase_next = PH_VERTS;
                            left_next  = {7'd0, vcount_reg, 1'b0} + {8'd0, vcount_reg};
                        end
                    end
                    PH_VERTS: begin
                        asm_next = asm_reg | (64'(in_byte) << {s8, 3'b000});
                        if (s8 == 3'd7) begin
                            data_vld            = 1'b1;
                            data_res.kind       = KIND_COORD;
                            data_res.coord_bits = asm_next;
                            asm_next            = '0;
                            left_next           = left_reg - 40'd1;
                        end
                    end
                    PH_FACES: begin
                        asm_next = asm_reg | (64'(in_byte) << {s4, 3'b000});
                        if (s4 == 2'd3) begin
                            data_vld            = 1'b1;
                            data_res.kind       = KIND_FACE;
                            data_res.face_index = asm_next[31:0];
                            asm_next            = '0;
                            left_next           = left_reg - 40'd1;
                        end
                    end
                    PH_SKIP_N, PH_SKIP_U: begin
                        left_next = left_reg - 40'd1;
                    end
                    default: begin
                    end
                endcase
            end

            pos_next = pos_reg + 4'd1;
            aligned  = (pos_next[2:0] == 3'd0);

            // Chain of zero-length section transitions
            if (phase_next == PH_VERTS && left_next == 40'd0) begin
                phase_next = PH_FACES;
                left_next  = {8'd0, fcount_next};
            end
            if (phase_next == PH_FACES && left_next == 40'd0) phase_next = PH_PAD_N;
            if (phase_next == PH_PAD_N) begin
                if (!flags_next[FLAG_NORMALS]) begin
                    phase_next = PH_PAD_U;
                end else if (aligned) begin
                    phase_next = PH_SKIP_N;
                    left_next  = {3'd0, vcount_next, 5'd0} - {5'd0, vcount_next, 3'd0};
                end
            end
            if (phase_next == PH_SKIP_N && left_next == 40'd0) phase_next = PH_PAD_U;
            if (phase_next == PH_PAD_U) begin
                if (!flags_next[FLAG_UVS]) begin
                    phase_next = PH_DONE;
                end else if (aligned) begin
                    phase_next = PH_SKIP_U;
                    left_next  = {4'd0, vcount_next, 4'd0};
                end
            end
            if (phase_next == PH_SKIP_U && left_next == 40'd0) phase_next = PH_DONE;

            if (in_eob) begin
                not_plain         = (prim_next != 8'd0) || flags_next[FLAG_NOT_PLAIN];
                fin_res.kind      = KIND_STATUS;
                fin_res.final_res = 1'b1;
                if (phase_next == PH_HEADER) begin
                    fin_res.status = ST_TOO_SMALL;
                end else begin
                    if (units_next >= 16'd1 && units_next <= 16'd8) begin
                        fin_res.units = units_next[3:0];
                    end
                    priority if (herr_next == HERR_MAGIC) fin_res.status = ST_BAD_MAGIC;
                    else if (herr_next == HERR_VER) fin_res.status = ST_BAD_VER;
                    else if (~crc_next != exp_crc_next) fin_res.status = ST_CRC;
                    else if (not_plain) fin_res.status = ST_NOT_PLAIN;
                    else if (phase_next != PH_DONE) fin_res.status = ST_TRUNC;
                    else fin_res.status = ST_OK;
                end
                // back to the start of a new buffer
                pos_next     = '0;
                phase_next   = PH_HEADER;
                asm_next     = '0;
                flags_next   = '0;
                prim_next    = '0;
                units_next   = '0;
                exp_crc_next = '0;
                crc_next     = CRC_INIT;
                vcount_next  = '0;
                fcount_next  = '0;
                left_next    = '0;
                herr_next    = HERR_NONE;
            end
        end

        push.count = 2'({1'b0, data_vld} + {1'b0, in_acc & in_eob});
        push.res0  = data_vld ? data_res : fin_res;
        push.res1  = fin_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            phase_reg   <= PH_HEADER;
            asm_reg     <= '0;
            flags_reg   <= '0;
            prim_reg    <= '0;
            units_reg   <= '0;
            exp_crc_reg <= '0;
            crc_reg     <= CRC_INIT;
            vcount_reg  <= '0;
            fcount_reg  <= '0;
            left_reg    <= '0;
            herr_reg    <= HERR_NONE;
        end else begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            asm_reg     <= asm_next;
            flags_reg   <= flags_next;
            prim_reg    <= prim_next;
            units_reg   <= units_next;
            exp_crc_reg <= exp_crc_next;
            crc_reg     <= crc_next;
            vcount_reg  <= vcount_next;
            fcount_reg  <= fcount_next;
            left_reg    <= left_next;
            herr_reg    <= herr_next;
        end
    end

endmodule

[hdl/mcbp_out_fifo.sv]
module mcbp_out_fifo
    import mcbp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    space_ok,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]    count_reg, count_next;
    logic                pop;

    // room for the worst case of two results from one byte
    assign space_ok  = (count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) mem[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2) mem[wr_ptr_reg + FIFO_AW'(1)] <= push.res1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[tb/sv/mesh_container_byte_parser_core_tb.sv]
`timescale 1ns / 1ps

module mesh_container_byte_parser_core_tb;
    import mcbp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_BYTES = 700;
    localparam int unsigned BODY_CAP     = 400;   // content cap for huge claimed counts
    localparam int unsigned HOLD_AT      = 700;   // bytes in before the long m_axis stall
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned SETTLE_WAIT  = 20;

    // Header magic, byte 0 in the low bits
    localparam logic [31:0] HDR_MAGIC_LE = 32'h4F45_4753;

    // Fault selectors for container construction
    localparam int FAULT_MAGIC = 0;
    localparam int FAULT_VER   = 1;
    localparam int FAULT_CRC   = 2;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;   // hold this byte until every pending result is out
    } stream_byte_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    mesh_container_byte_parser_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    stream_byte_t byte_stream[$];
    result_t      expected_results[$];
    int unsigned  bytes_in = 0;
    int unsigned  results_out = 0;
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;
    int unsigned  s_wait = 0;
    int unsigned  m_wait = 0;
    int unsigned  hold_left = 0;
    bit           hold_done = 1'b0;

    // ------------------------------------------------------------------
    // Parser prediction: shadow state, advanced once per accepted byte
    // ------------------------------------------------------------------
    logic [39:0] pos_q;
    logic [3:0]  phase_q;
    logic [63:0] word_q;
    logic [15:0] flags_q;
    logic [7:0]  prim_q;
    logic [15:0] units_q;
    logic [31:0] want_crc_q;
    logic [31:0] crc_q;
    logic [31:0] vcnt_q;
    logic [31:0] fcnt_q;
    logic [39:0] left_q;
    logic [1:0]  herr_q;

    function automatic logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void parser_clear();
        pos_q      = '0;
        phase_q    = PH_HEADER;
        word_q     = '0;
        flags_q    = '0;
        prim_q     = '0;
        units_q    = '0;
        want_crc_q = '0;
        crc_q      = CRC_INIT;
        vcnt_q     = '0;
        fcnt_q     = '0;
        left_q     = '0;
        herr_q     = HERR_NONE;
    endfunction

    function automatic bit hdr_not_plain();
        return prim_q != 8'd0 || flags_q[FLAG_NOT_PLAIN];
    endfunction

    // Fall through finished sections; padding waits for 8-byte alignment
    function automatic void settle_phase();
        bit aligned;
        aligned = (pos_q[2:0] == 3'd0);
        if (phase_q == PH_VERTS && left_q == '0) begin
            phase_q = PH_FACES;
            left_q  = {8'd0, fcnt_q};
        end
        if (phase_q == PH_FACES && left_q == '0)
            phase_q = PH_PAD_N;
        if (phase_q == PH_PAD_N) begin
            if (!flags_q[FLAG_NORMALS]) begin
                phase_q = PH_PAD_U;
            end else if (aligned) begin
                phase_q = PH_SKIP_N;
                left_q  = {8'd0, vcnt_q} * 40'd24;
            end
        end
        if (phase_q == PH_SKIP_N && left_q == '0)
            phase_q = PH_PAD_U;
        if (phase_q == PH_PAD_U) begin
            if (!flags_q[FLAG_UVS]) begin
                phase_q = PH_DONE;
            end else if (aligned) begin
                phase_q = PH_SKIP_U;
                left_q  = {8'd0, vcnt_q} * 40'd16;
            end
        end
        if (phase_q == PH_SKIP_U && left_q == '0)
            phase_q = PH_DONE;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic eob);
        logic [3:0] idx;
        logic [1:0] s4;
        logic [2:0] s8;
        result_t    r;
        idx = pos_q[3:0];
        s4  = pos_q[1:0];
        s8  = pos_q[2:0];
        if (phase_q == PH_HEADER) begin
            if (idx < HDR_VERSION) begin
                if (b != HDR_MAGIC_LE[8*idx +: 8] && herr_q == HERR_NONE)
                    herr_q = HERR_MAGIC;
            end else if (idx == HDR_VERSION) begin
                if (b != VERSION_ONE && herr_q == HERR_NONE)
                    herr_q = HERR_VER;
            end else if (idx == HDR_PRIM) begin
                prim_q = b;
            end else if (idx == HDR_FLAGS0 || idx == HDR_FLAGS1) begin
                flags_q = flags_q | ({8'd0, b} << (8 * (idx - HDR_FLAGS0)));
            end else if (idx == HDR_UNITS0 || idx == HDR_UNITS1) begin
                units_q = units_q | ({8'd0, b} << (8 * (idx - HDR_UNITS0)));
            end else if (idx >= HDR_CRC0) begin
                want_crc_q = want_crc_q | ({24'd0, b} << (8 * (idx - HDR_CRC0)));
            end
            if (idx == HDR_LAST)
                phase_q = (herr_q != HERR_NONE || hdr_not_plain()) ? PH_IDLE : PH_VCOUNT;
        end else begin
            crc_q = crc32_update(crc_q, b);
            case (phase_q)
                PH_VCOUNT: begin
                    vcnt_q = vcnt_q | ({24'd0, b} << (8 * s4));
                    if (s4 == 2'd3)
                        phase_q = PH_FCOUNT;
                end
                PH_FCOUNT: begin
                    fcnt_q = fcnt_q | ({24'd0, b} << (8 * s4));
                    if (s4 == 2'd3) begin
                        phase_q = PH_VERTS;
                        left_q  = {8'd0, vcnt_q} * 40'd3;
                    end
                end
                PH_VERTS: begin
                    word_q = word_q | ({56'd0, b} << (8 * s8));
                    if (s8 == 3'd7) begin
                        r            = '0;
                        r.kind       = KIND_COORD;
                        r.coord_bits = word_q;
                        expected_results.push_back(r);
                        word_q = '0;
                        left_q = left_q - 40'd1;
                    end
                end
                PH_FACES: begin
                    word_q = word_q | ({56'd0, b} << (8 * s4));
                    if (s4 == 2'd3) begin
                        r            = '0;
                        r.kind       = KIND_FACE;
                        r.face_index = word_q[31:0];
                        expected_results.push_back(r);
                        word_q = '0;
                        left_q = left_q - 40'd1;
                    end
                end
                PH_SKIP_N, PH_SKIP_U: left_q = left_q - 40'd1;
                default: ;
            endcase
        end
        pos_q = pos_q + 40'd1;
        settle_phase();

        if (eob) begin
            r           = '0;
            r.kind      = KIND_STATUS;
            r.final_res = 1'b1;
            if (phase_q == PH_HEADER) begin
                r.status = ST_TOO_SMALL;
            end else begin
                r.units = (units_q >= 16'd1 && units_q <= 16'd8) ? units_q[3:0] : 4'd0;
                if (herr_q == HERR_MAGIC)
                    r.status = ST_BAD_MAGIC;
                else if (herr_q == HERR_VER)
                    r.status = ST_BAD_VER;
                else if (~crc_q != want_crc_q)
                    r.status = ST_CRC;
                else if (hdr_not_plain())
                    r.status = ST_NOT_PLAIN;
                else if (phase_q != PH_DONE)
                    r.status = ST_TRUNC;
                else
                    r.status = ST_OK;
            end
            expected_results.push_back(r);
            parser_clear();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_units();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 8));
            1:       return 16'($urandom_range(9, 15));
            2:       return 16'hFFFF;
            3:       return 16'h0100 | 16'($urandom_range(1, 8));
            4:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    // Payload byte; extreme mode gives all-zero/all-one patterns
    function automatic logic [7:0] payload_byte(bit extreme);
        if (extreme)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Build one container and queue it. Counts are the claimed header counts; content
    // stops at BODY_CAP, and cut (when > 0) trims the buffer to that many bytes.
    task automatic queue_container(input logic [31:0] vcnt, input logic [31:0] fcnt,
                                   input logic [15:0] flags, input logic [7:0] prim,
                                   input logic [15:0] units, input logic [2:0] faults,
                                   input int unsigned cut, input int unsigned tail,
                                   input bit extreme, input bit drain);
        logic [7:0]   c[$];
        logic [7:0]   ver;
        logic [31:0]  crc;
        longint unsigned n;
        stream_byte_t sb;
        int unsigned  k;
        for (k = 0; k < 4; k++)
            c.push_back(HDR_MAGIC_LE[8*k +: 8]);
        if (faults[FAULT_MAGIC]) begin
            k = $urandom_range(0, 3);
            c[k] = c[k] ^ 8'($urandom_range(1, 255));
        end
        ver = 8'($urandom_range(0, 255));
        if (ver == VERSION_ONE)
            ver = 8'hFE;
        c.push_back(faults[FAULT_VER] ? ver : VERSION_ONE);
        c.push_back(prim);
        c.push_back(flags[7:0]);
        c.push_back(flags[15:8]);
        c.push_back(units[7:0]);
        c.push_back(units[15:8]);
        c.push_back(8'($urandom_range(0, 255)));
        c.push_back(8'($urandom_range(0, 255)));
        for (k = 0; k < 4; k++)
            c.push_back(8'd0);           // CRC slot, filled below
        for (k = 0; k < 4; k++)
            c.push_back(vcnt[8*k +: 8]);
        for (k = 0; k < 4; k++)
            c.push_back(fcnt[8*k +: 8]);
        for (n = 0; n < 64'(vcnt) * 24 && c.size() < BODY_CAP; n++)
            c.push_back(payload_byte(extreme));
        for (n = 0; n < 64'(fcnt) * 4 && c.size() < BODY_CAP; n++)
            c.push_back(payload_byte(extreme));
        if (flags[FLAG_NORMALS]) begin
            while (c.size() % 8 != 0)
                c.push_back(payload_byte(1'b0));
            for (n = 0; n < 64'(vcnt) * 24 && c.size() < BODY_CAP; n++)
                c.push_back(payload_byte(extreme));
        end
        if (flags[FLAG_UVS]) begin
            while (c.size() % 8 != 0)
                c.push_back(payload_byte(1'b0));
            for (n = 0; n < 64'(vcnt) * 16 && c.size() < BODY_CAP; n++)
                c.push_back(payload_byte(extreme));
        end
        for (k = 0; k < tail; k++)
            c.push_back(payload_byte(1'b0));
        if (cut != 0)
            while (c.size() > cut)
                void'(c.pop_back());

        // CRC over everything past the header, as it is actually sent
        crc = CRC_INIT;
        for (k = 16; k < c.size(); k++)
            crc = crc32_update(crc, c[k]);
        crc = ~crc;
        if (faults[FAULT_CRC])
            crc = crc ^ (32'($urandom()) | 32'd1);
        for (k = HDR_CRC0; k < 16 && k < c.size(); k++)
            c[k] = crc[8*(k - HDR_CRC0) +: 8];

        for (k = 0; k < c.size(); k++) begin
            sb.data  = c[k];
            sb.last  = (k == c.size() - 1);
            sb.drain = drain && (k == 0);
            byte_stream.push_back(sb);
        end
    endtask

    task automatic queue_noise(input int unsigned len);
        stream_byte_t sb;
        for (int unsigned k = 0; k < len; k++) begin
            sb.data  = 8'($urandom_range(0, 255));
            sb.last  = (k == len - 1);
            sb.drain = 1'b0;
            byte_stream.push_back(sb);
        end
    endtask

    task automatic queue_random_container(input bit drain);
        logic [31:0] vcnt;
        logic [31:0] fcnt;
        logic [15:0] flags;
        logic [7:0]  prim;
        logic [2:0]  faults;
        int unsigned cut;
        int unsigned tail;
        int unsigned sel;
        vcnt   = $urandom_range(0, 3);
        fcnt   = $urandom_range(0, 6);
        flags  = 16'($urandom_range(0, 65535));
        flags[FLAG_NOT_PLAIN] = 1'b0;
        prim   = 8'd0;
        faults = '0;
        cut    = 0;
        tail   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        sel    = $urandom_range(0, 99);
        if (sel < 60) begin
            // well-formed plain mesh
        end else if (sel < 72) begin
            cut = $urandom_range(1, 120);                 // truncated buffer
        end else if (sel < 80) begin
            faults = 3'($urandom_range(1, 7));            // header/CRC faults
        end else if (sel < 88) begin
            if ($urandom_range(0, 1))
                prim = 8'($urandom_range(1, 255));
            else
                flags[FLAG_NOT_PLAIN] = 1'b1;
        end else if (sel < 94) begin
            vcnt = $urandom();                            // huge claimed counts
            fcnt = $urandom_range(0, 1) ? $urandom() : 32'd0;
            cut  = $urandom_range(17, BODY_CAP);
        end else begin
            queue_noise($urandom_range(1, 40));
            return;
        end
        queue_container(vcnt, fcnt, flags, prim, pick_units(), faults, cut, tail,
                        $urandom_range(0, 3) == 0, drain);
    endtask

    // ------------------------------------------------------------------
    // s_axis driver; the byte taken at this edge is predicted here too
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : byte_driver
        stream_byte_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_wait        <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tlast);
                bytes_in <= bytes_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_wait != 0) begin
                    s_axis_tvalid <= 1'b0;
                    s_wait        <= s_wait - 1;
                end else if (byte_stream.size() != 0 &&
                             !(byte_stream[0].drain && expected_results.size() != 0)) begin
                    nxt = byte_stream.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.last;
                    // every 256 bytes, a stretch of back-to-back transfers
                    s_wait <= ((bytes_in % 256) >= 192) ? 0 : pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long m_axis stall while bytes keep coming: the result queue fills and
    // s_axis_tready must drop
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_in >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // m_axis ready with random backpressure
    always @(posedge aclk) begin : result_sink
        int unsigned g;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            m_wait        <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (m_wait != 0) begin
            m_axis_tready <= 1'b0;
            m_wait        <= m_wait - 1;
        end else if (m_axis_tvalid && m_axis_tready && (results_out % 128) < 96) begin
            g = pick_gap();
            if (g == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                m_wait        <= g - 1;
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // m_axis monitor: compare each transfer with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_out <= results_out + 1;
            if (expected_results.size() == 0) begin
                $error("result transfer with none pending: kind 0x%0h, tdata 0x%0h",
                       m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", 64'(want.kind), 64'(m_axis_tuser));
                compare_field("coord_bits", want.coord_bits, m_axis_tdata[63:0]);
                compare_field("face_index", 64'(want.face_index), 64'(m_axis_tdata[95:64]));
                compare_field("status", 64'(want.status), 64'(m_axis_tdata[98:96]));
                compare_field("units", 64'(want.units), 64'(m_axis_tdata[102:99]));
                compare_field("final_res", 64'(want.final_res), 64'(m_axis_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned directed_len;
        parser_clear();

        // single byte and a header fragment with bad magic: both too small
        queue_container(0, 0, 16'h0000, 8'd0, 16'd1, 3'b000, 1, 0, 1'b0, 1'b0);
        queue_container(0, 0, 16'h0000, 8'd0, 16'd1, 3'b001, 15, 0, 1'b0, 1'b0);
        // header only: truncated at the vertex count
        queue_container(0, 0, 16'h0000, 8'd0, 16'd3, 3'b000, 16, 0, 1'b0, 1'b0);
        // empty mesh, largest units code
        queue_container(0, 0, 16'h0000, 8'd0, 16'd8, 3'b000, 0, 0, 1'b0, 1'b0);
        // normals and UVs skipped after padding, unmapped units, extreme payload
        queue_container(1, 3, 16'hFFFE, 8'd0, 16'hFFFF, 3'b000, 0, 0, 1'b1, 1'b1);
        // header faults: magic wins over version, then version, then CRC
        queue_container(1, 1, 16'h0000, 8'd0, 16'd2, 3'b011, 0, 0, 1'b0, 1'b0);
        queue_container(1, 1, 16'h0000, 8'd0, 16'd4, 3'b010, 0, 0, 1'b0, 1'b0);
        queue_container(1, 1, 16'h0001, 8'd0, 16'd5, 3'b100, 0, 0, 1'b0, 1'b0);
        // not a plain mesh, by primitive and by flag
        queue_container(1, 1, 16'h0000, 8'hFF, 16'd6, 3'b000, 0, 0, 1'b0, 1'b0);
        queue_container(1, 1, 16'h0001, 8'd0, 16'd7, 3'b000, 0, 0, 1'b0, 1'b0);
        // truncated in the coordinates
        queue_container(2, 2, 16'h0000, 8'd0, 16'd9, 3'b000, 40, 0, 1'b0, 1'b0);
        // last byte completes a face word: face and status from one byte
        queue_container(1, 1, 16'h0000, 8'd0, 16'd1, 3'b000, 0, 0, 1'b1, 1'b0);
        // trailing bytes after the faces
        queue_container(0, 1, 16'h0000, 8'd0, 16'd0, 3'b000, 0, 5, 1'b0, 1'b0);
        directed_len = byte_stream.size();

        // the first random container waits for the queue to drain
        queue_random_container(1'b1);
        while (byte_stream.size() < directed_len + RANDOM_BYTES)
            queue_random_container($urandom_range(0, 29) == 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_stream.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
hdl/mcbp_pkg.sv
hdl/mcbp_parser.sv
hdl/mcbp_out_fifo.sv
hdl/mesh_container_byte_parser_core.sv
tb/sv/mesh_container_byte_parser_core_tb.sv
